>>> rtl/core/cal_pkg.sv
// cal_pkg: shared sizes, op and status codes, and the per-cycle command
// broadcast to the cell chain of the cursor list. No dependencies.
package cal_pkg;

  localparam int DEPTH = 64;
  localparam int WIDTH = 32;
  localparam int CNTW  = $clog2(DEPTH + 1);  // holds 0..DEPTH
  localparam int GRP   = 8;                  // cells per first-level OR group
  localparam int NGRP  = (DEPTH + GRP - 1) / GRP;

  localparam int OP_W  = 4;
  localparam int DIN_W = 32;
  localparam int POS_W = 7;
  localparam int ST_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 4'd0,
    OP_INSERT  = 4'd1,
    OP_APPEND  = 4'd2,
    OP_REMOVE  = 4'd3,
    OP_START   = 4'd4,
    OP_END     = 4'd5,
    OP_BACK    = 4'd6,
    OP_FORWARD = 4'd7,
    OP_SEEK    = 4'd8,
    OP_READ    = 4'd9
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_NOCUR = 3'd2,
    ST_BOUND = 3'd3,
    ST_RANGE = 3'd4
  } status_t;

  typedef struct packed {
    logic             ins;
    logic             app;
    logic             rem;
    logic             cap;   // latch cursor-entry pick into the OR groups
    logic [CNTW-1:0]  cur;
    logic [CNTW-1:0]  cnt;
    logic [WIDTH-1:0] val;
  } cmd_t;

endpackage

>>> rtl/core/cal_cell.sv
// cal_cell: one list entry. Loads the new value, its left or right neighbor
// according to the broadcast command. Depends on cal_pkg.
module cal_cell import cal_pkg::*; (
  input  logic             clk,
  input  cmd_t             cmd,
  input  logic [CNTW-1:0]  idx,
  input  logic [WIDTH-1:0] left_i,
  input  logic [WIDTH-1:0] right_i,
  output logic [WIDTH-1:0] data_o,
  output logic [WIDTH-1:0] pick_o
);

  logic [WIDTH-1:0] data_r;
  logic [WIDTH-1:0] data_nxt;
  logic             at_cur;
  logic             above_cur;

  assign at_cur    = (idx == cmd.cur);
  assign above_cur = (idx > cmd.cur);

  always_comb begin
    data_nxt = data_r;
    if (cmd.ins) begin
      if (at_cur) data_nxt = cmd.val;
      else if (above_cur) data_nxt = left_i;
    end else if (cmd.app) begin
      if (idx == cmd.cnt) data_nxt = cmd.val;
    end else if (cmd.rem) begin
      if (at_cur || above_cur) data_nxt = right_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  assign pick_o = at_cur ? data_r : '0;

endmodule

>>> rtl/core/cal_chain.sv
// cal_chain: the row of entry cells plus the registered first level of the
// OR tree that picks the entry at the cursor. Depends on cal_pkg, cal_cell.
module cal_chain import cal_pkg::*; (
  input  logic             clk,
  input  cmd_t             cmd,
  output logic [WIDTH-1:0] grp_o [NGRP]
);

  logic [WIDTH-1:0] data [DEPTH];
  logic [WIDTH-1:0] pick [NGRP*GRP];
  logic [WIDTH-1:0] grp_r [NGRP];
  logic [WIDTH-1:0] grp_nxt [NGRP];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] left_w;
    logic [WIDTH-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = data[i+1];
    end
    cal_cell u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .idx     (CNTW'(i)),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (data[i]),
      .pick_o  (pick[i])
    );
  end

  for (genvar j = DEPTH; j < NGRP*GRP; j++) begin : g_pad
    assign pick[j] = '0;
  end

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        grp_nxt[g] = grp_nxt[g] | pick[g*GRP + k];
      end
    end
  end

  // sampled with the pre-op contents, same edge as any shift
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      grp_r <= grp_nxt;
    end
  end

  assign grp_o = grp_r;

endmodule

>>> rtl/core/cursor_array_list.sv
// cursor_array_list: ordered list with cursor, one op per input word.
// An accepted word's cursor-entry pick is registered in the first-level
// OR groups as the FSM enters S_RED; there the second OR-tree level
// loads the output register, and no new word is taken in S_RED. The
// result sits in that register; the next word is taken as it drains.
// Reset (rst_n, synchronous): count, cursor, FSM and output valid clear;
// entry contents are not cleared. Depends on cal_pkg, cal_chain.
module cursor_array_list import cal_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // op[3:0], data_in[35:4], target_pos[42:36]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // data_out[31:0], status[34:32], count[41:35],
                                  // cursor_pos[48:42]
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RED  = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;
  logic [CNTW-1:0]  cursor_r, cursor_nxt;
  status_t          st_r, st_nxt;
  logic             rd_r, rd_nxt;
  logic             ovalid_r, ovalid_nxt;
  logic [WIDTH-1:0] odata_r;
  status_t          ost_r;
  logic [CNTW-1:0]  ocnt_r;
  logic [CNTW-1:0]  ocur_r;

  op_t              op;
  logic [WIDTH-1:0] din;
  logic [POS_W-1:0] tpos;
  logic             accept;
  cmd_t             cmd;
  logic [WIDTH-1:0] grp [NGRP];
  logic [WIDTH-1:0] picked;
  logic [CNTW:0]    cur_inc;

  assign op     = op_t'(in_tdata[3:0]);
  assign din    = in_tdata[35:4];
  assign tpos   = in_tdata[42:36];
  assign in_tready = (state_r == S_IDLE) && (!ovalid_r || out_tready);
  assign accept = in_tvalid && in_tready;
  assign cur_inc = {1'b0, cursor_r} + 1'b1;

  always_comb begin
    cmd        = '0;
    cmd.cur    = cursor_r;
    cmd.cnt    = count_r;
    cmd.val    = din;
    cmd.cap    = accept;
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    st_nxt     = st_r;
    rd_nxt     = rd_r;
    if (accept) begin
      st_nxt = ST_OK;
      rd_nxt = 1'b0;
      case (op)
        OP_CLEAR: begin
          count_nxt  = '0;
          cursor_nxt = '0;
        end
        OP_INSERT: begin
          if (count_r >= CNTW'(DEPTH)) st_nxt = ST_FULL;
          else begin
            cmd.ins   = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_APPEND: begin
          if (count_r >= CNTW'(DEPTH)) st_nxt = ST_FULL;
          else begin
            cmd.app   = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (cursor_r >= count_r) st_nxt = ST_NOCUR;
          else begin
            cmd.rem   = 1'b1;
            rd_nxt    = 1'b1;
            count_nxt = count_r - 1'b1;
          end
        end
        OP_START: cursor_nxt = '0;
        OP_END: cursor_nxt = (count_r == '0) ? '0 : count_r - 1'b1;
        OP_BACK: begin
          if (cursor_r == '0) st_nxt = ST_BOUND;
          else cursor_nxt = cursor_r - 1'b1;
        end
        OP_FORWARD: begin
          if (cur_inc >= {1'b0, count_r}) st_nxt = ST_BOUND;
          else cursor_nxt = cur_inc[CNTW-1:0];
        end
        OP_SEEK: begin
          if ({{(CNTW+1-POS_W){1'b0}}, tpos} > {1'b0, count_r}) st_nxt = ST_RANGE;
          else cursor_nxt = CNTW'(tpos);
        end
        OP_READ: begin
          if (cursor_r >= count_r) st_nxt = ST_NOCUR;
          else rd_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  cal_chain u_chain (
    .clk   (clk),
    .cmd   (cmd),
    .grp_o (grp)
  );

  always_comb begin
    picked = '0;
    for (int g = 0; g < NGRP; g++) begin
      picked = picked | grp[g];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r;
    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_RED;
      S_RED: begin
        state_nxt  = S_IDLE;
        ovalid_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      cursor_r <= '0;
      ovalid_r <= 1'b0;
      st_r     <= ST_OK;
      rd_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
      ovalid_r <= ovalid_nxt;
      st_r     <= st_nxt;
      rd_r     <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RED) begin
      odata_r <= rd_r ? picked : '0;
      ost_r   <= st_r;
      ocnt_r  <= count_r;
      ocur_r  <= cursor_r;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {7'b0, 7'(ocur_r), 7'(ocnt_r), ost_r, 32'(odata_r)};

endmodule
